// File: rtl/lsps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LED and servo pattern sequencer.
// No dependencies; used by the top level and its port checker.
package lsps_pkg;

    localparam int PROG_STEPS = 32;
    localparam int STEP_W     = $clog2(PROG_STEPS);
    localparam int STEP_CW    = STEP_W + 1;

    localparam int REQ_W   = 3;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 12;
    localparam int S_DW    = 48;
    localparam int M_DW    = 40;

    localparam logic [11:0] PULSE_MAX       = 12'hFFF;
    localparam logic [11:0] RST_PULSE_OFS   = 12'd1300;
    localparam logic [2:0]  RST_PULSE_GAIN  = 3'd2;
    localparam logic [7:0]  RST_IDLE_TICKS  = 8'd80;
    localparam logic [3:0]  RST_STEP_DIV    = 4'd10;
    localparam logic [7:0]  RST_IDLE_COUNT  = 8'd4;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 3'd0,
        REQ_PLAY  = 3'd1,
        REQ_STOP  = 3'd2,
        REQ_SET   = 3'd3,
        REQ_WRITE = 3'd4
    } req_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_PULSE_OFS  = 2'd0,
        CFG_PULSE_GAIN = 2'd1,
        CFG_IDLE_TICKS = 2'd2,
        CFG_STEP_DIV   = 2'd3
    } cfg_reg_t;

endpackage

// File: rtl/led_servo_pattern_sequencer_top.sv
`timescale 1ns / 1ps
// LED and servo pattern sequencer: top level with input register, update logic
// and result register. Depends on lsps_pkg.
//
// One result item per input item, one item per clock cycle sustained while
// m_tready holds: an input register holds the request, the update logic
// works on it against the stored state and the result register shows the state
// after it. The program word of the step that plays next is prefetched each
// cycle from a 32-entry store with one registered read port, with a bypass for
// a write to that same entry; a per-entry nonzero flag settles the end of a
// pass. Reset clears the store at once through per-entry valid flags. Users
// must give configuration writes only while the block is idle; not enforced.
module led_servo_pattern_sequencer_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // play_count[7:0], led_value[14:8], arm_value[22:15], entry_index[27:23],
    // entry_word[43:28], zero[47:44]
    input  logic [lsps_pkg::S_DW-1:0]   s_tdata,
    // req_type[2:0]
    input  logic [lsps_pkg::REQ_W-1:0]  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // led_state[6:0], pulse_width_us[18:7], arm_position[26:19],
    // current_step[31:27], loops_left[39:32]
    output logic [lsps_pkg::M_DW-1:0]   m_tdata,
    input  logic                        cfg_we,
    input  logic [lsps_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [lsps_pkg::CFG_DW-1:0] cfg_wdata
);

    localparam int SW = lsps_pkg::STEP_W;

    // configuration
    logic [11:0] ofs_reg;
    logic [2:0]  gain_reg;
    logic [7:0]  idle_ticks_reg;
    logic [3:0]  div_reg;

    // input register
    logic                       s1_valid_reg;
    logic [lsps_pkg::REQ_W-1:0] s1_req_reg;
    logic [43:0]                s1_data_reg;

    // result register
    logic                       m_valid_reg;
    logic [lsps_pkg::M_DW-1:0]  m_data_reg;

    // sequencer state
    logic [3:0]    presc_reg,  presc_next;
    logic [7:0]    loops_reg,  loops_next;
    logic [SW-1:0] step_reg,   step_next;
    logic [7:0]    rem_reg,    rem_next;
    logic [7:0]    cd_reg,     cd_next;
    logic [11:0]   pulse_reg,  pulse_next;
    logic [6:0]    led_reg,    led_next;

    // program store
    logic [15:0]                   mem [lsps_pkg::PROG_STEPS];
    logic [lsps_pkg::PROG_STEPS-1:0] vld_reg;
    logic [lsps_pkg::PROG_STEPS-1:0] nz_reg;
    logic [15:0]                   mem_rd_reg;
    logic                          vld_rd_reg;
    logic                          byp_reg;
    logic [15:0]                   byp_word_reg;
    logic [15:0]                   cur_word;

    logic                 out_free;
    logic                 s1_go;
    logic                 mem_we;
    logic [7:0]           play_cnt;
    logic [6:0]           led_val;
    logic [7:0]           arm_val;
    logic [SW-1:0]        widx;
    logic [15:0]          wword;
    logic [3:0]           presc_inc;
    logic [lsps_pkg::STEP_CW-1:0] step_inc;
    logic                 fire;
    logic                 pass_end;
    logic                 arm_upd;
    logic [7:0]           arm_pos;
    logic [10:0]          gain_prod;
    logic [12:0]          pulse_sum;
    logic [11:0]          pulse_calc;

    assign out_free = !m_valid_reg || m_tready;
    assign s1_go    = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || s1_go;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign play_cnt = s1_data_reg[7:0];
    assign led_val  = s1_data_reg[14:8];
    assign arm_val  = s1_data_reg[22:15];
    assign widx     = s1_data_reg[23 +: SW];
    assign wword    = s1_data_reg[43:28];

    assign cur_word = byp_reg ? byp_word_reg : (vld_rd_reg ? mem_rd_reg : 16'd0);

    assign presc_inc = presc_reg + 4'd1;
    assign fire      = presc_inc >= div_reg;
    assign step_inc  = {1'b0, step_reg} + lsps_pkg::STEP_CW'(1);
    assign pass_end  = (step_inc == lsps_pkg::STEP_CW'(lsps_pkg::PROG_STEPS))
                       || !nz_reg[step_inc[SW-1:0]];

    assign gain_prod  = gain_reg * arm_pos;
    assign pulse_sum  = {1'b0, ofs_reg} + {2'b00, gain_prod};
    assign pulse_calc = (arm_pos == 8'd0) ? 12'd0
                      : (pulse_sum[12] ? lsps_pkg::PULSE_MAX : pulse_sum[11:0]);

    always_comb
    begin
        presc_next = presc_reg;
        loops_next = loops_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        cd_next    = cd_reg;
        pulse_next = pulse_reg;
        led_next   = led_reg;
        mem_we     = 1'b0;
        arm_upd    = 1'b0;
        arm_pos    = 8'd0;

        if (s1_go)
        begin
            case (lsps_pkg::req_t'(s1_req_reg))
                lsps_pkg::REQ_TICK:
                begin
                    presc_next = fire ? 4'd0 : presc_inc;
                    if (fire && loops_reg != 8'd0)
                    begin
                        led_next = cur_word[6:0];
                        arm_upd  = 1'b1;
                        arm_pos  = cur_word[15:8];
                        if (pass_end)
                        begin
                            loops_next = loops_reg - 8'd1;
                            step_next  = '0;
                        end
                        else
                        begin
                            step_next = step_inc[SW-1:0];
                        end
                    end
                end
                lsps_pkg::REQ_PLAY:
                begin
                    if (loops_reg == 8'd0)
                    begin
                        loops_next = (play_cnt == 8'd0) ? 8'd1 : play_cnt;
                    end
                end
                lsps_pkg::REQ_STOP:
                begin
                    loops_next = 8'd0;
                    step_next  = '0;
                end
                lsps_pkg::REQ_SET:
                begin
                    loops_next = 8'd0;
                    step_next  = '0;
                    led_next   = led_val;
                    arm_upd    = 1'b1;
                    arm_pos    = arm_val;
                end
                lsps_pkg::REQ_WRITE:
                begin
                    mem_we = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // new arm position: reload the idle countdown and set the pulse
        if (arm_upd && arm_pos != rem_reg)
        begin
            cd_next    = idle_ticks_reg;
            pulse_next = pulse_calc;
        end
        if (arm_upd && arm_pos != 8'd0)
        begin
            rem_next = arm_pos;
        end

        // idle countdown on a tick: when spent with an arm position remembered, drop the pulse and reload
        if (s1_go && lsps_pkg::req_t'(s1_req_reg) == lsps_pkg::REQ_TICK)
        begin
            if (cd_next == 8'd0)
            begin
                if (rem_next != 8'd0)
                begin
                    cd_next    = idle_ticks_reg;
                    pulse_next = 12'd0;
                end
            end
            else
            begin
                cd_next = cd_next - 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs_reg        <= lsps_pkg::RST_PULSE_OFS;
            gain_reg       <= lsps_pkg::RST_PULSE_GAIN;
            idle_ticks_reg <= lsps_pkg::RST_IDLE_TICKS;
            div_reg        <= lsps_pkg::RST_STEP_DIV;
        end
        else if (cfg_we)
        begin
            unique case (lsps_pkg::cfg_reg_t'(cfg_addr))
                lsps_pkg::CFG_PULSE_OFS:  ofs_reg        <= cfg_wdata;
                lsps_pkg::CFG_PULSE_GAIN: gain_reg       <= cfg_wdata[2:0];
                lsps_pkg::CFG_IDLE_TICKS: idle_ticks_reg <= cfg_wdata[7:0];
                lsps_pkg::CFG_STEP_DIV:   div_reg        <= cfg_wdata[3:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            presc_reg    <= 4'd0;
            loops_reg    <= 8'd0;
            step_reg     <= '0;
            rem_reg      <= 8'd0;
            cd_reg       <= lsps_pkg::RST_IDLE_COUNT;
            pulse_reg    <= 12'd0;
            led_reg      <= 7'd0;
            vld_reg      <= '0;
            nz_reg       <= '0;
            vld_rd_reg   <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            presc_reg <= presc_next;
            loops_reg <= loops_next;
            step_reg  <= step_next;
            rem_reg   <= rem_next;
            cd_reg    <= cd_next;
            pulse_reg <= pulse_next;
            led_reg   <= led_next;

            if (mem_we)
            begin
                vld_reg[widx] <= 1'b1;
                nz_reg[widx]  <= (wword != 16'd0);
            end

            // prefetch the step that plays next
            vld_rd_reg <= vld_reg[step_next];
            byp_reg    <= mem_we && (widx == step_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_req_reg  <= s_tuser;
            s1_data_reg <= s_tdata[43:0];
        end
        if (s1_go)
        begin
            m_data_reg <= {loops_next, step_next, rem_next, pulse_next, led_next};
        end
        if (mem_we)
        begin
            mem[widx] <= wword;
        end
        mem_rd_reg   <= mem[step_next];
        byp_word_reg <= wword;
    end

endmodule

// File: rtl/lsps_chk.sv
`timescale 1ns / 1ps
// Port checker for the LED and servo pattern sequencer, bound to the top level.
// Depends on lsps_pkg.
module lsps_chk
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [lsps_pkg::M_DW-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[39:32] == 8'd0 |-> m_tdata[31:27] == 5'd0)
        else $error("step not at zero while no passes remain");

    a_pulse_arm: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[18:7] != 12'd0 |-> m_tdata[26:19] != 8'd0)
        else $error("pulse driven with no arm position remembered");

endmodule

bind led_servo_pattern_sequencer_top lsps_chk u_lsps_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
